// ===== hw/rtl/dfsc_pkg.sv =====
// shared constants, codes and controller/datapath link types for the framed exchange engine
package dfsc_pkg;

   // default depth of the command store
   localparam int unsigned CMD_DEPTH_DEFAULT = 16;

   // framing bytes on the line
   localparam logic [7:0] DLE_BYTE = 8'h10;
   localparam logic [7:0] STX_BYTE = 8'h02;
   localparam logic [7:0] ETX_BYTE = 8'h03;

   // number of tail bytes consumed after the body
   localparam logic [2:0] TAIL_LEN = 3'd3;

   // input item function codes
   localparam logic [1:0] FUNC_CMD  = 2'd0;
   localparam logic [1:0] FUNC_LINE = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_HOST   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // final status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_PROTO   = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // register map
   localparam int unsigned CSR_ADDR_W  = 4;
   localparam logic [1:0]  REG_TIMEOUT = 2'd0;
   localparam logic [1:0]  REG_START   = 2'd1;
   localparam logic [1:0]  REG_ACK     = 2'd2;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [7:0]  START_RESET   = 8'h02;
   localparam logic [7:0]  ACK_RESET     = 8'h10;

   // source of the byte placed in the result register
   typedef enum logic [2:0] {
      SEL_START,
      SEL_ACK,
      SEL_DLE,
      SEL_ETX,
      SEL_CHK,
      SEL_CMD,
      SEL_BODY,
      SEL_STATUS
   } sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       item_load;
      logic       load;
      sel_type    sel;
      logic       run_last;
      logic [1:0] status;
      logic       cmd_write;
      logic       wait_clr;
      logic       wait_inc;
      logic       finish_clr;
      logic       len_load;
      logic       body_step;
      logic       skip_clr;
      logic       tail_inc;
      logic       tail_clr;
      logic       walk_clr;
      logic       walk_inc;
   } dp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic [1:0] func;
      logic       last;
      logic       byte_dle;
      logic       byte_stx;
      logic       len_le1;
      logic       timed_out;
      logic       can_load;
      logic       skip;
      logic       body_done;
      logic       body_done_next;
      logic       tail_end;
      logic       rd_dle;
      logic       walk_end;
      logic       cnt_zero;
   } dp_stat_type;

endpackage

// ===== hw/rtl/dfsc_channels.sv =====
// valid/ready channel interfaces for request and response items

interface dfsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   logic       cmd_last;

   modport source (output valid, output func, output data_byte, output cmd_last, input ready);
   modport sink   (input valid, input func, input data_byte, input cmd_last, output ready);
endinterface

interface dfsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic [1:0] status;
   logic       run_last;

   modport source (output valid, output kind, output byte_value, output status,
                   output run_last, input ready);
   modport sink   (input valid, input kind, input byte_value, input status,
                   input run_last, output ready);
endinterface

// ===== hw/rtl/dle_framed_serial_command_exchange.sv =====
// top level of the framed serial command exchange engine
//
// req channel: one item per host command byte (func 0, cmd_last on the final
// byte), received line byte (func 1) or time tick (func 2).
// rsp channel: bytes to transmit (kind 0), response bytes for the host
// (kind 1) and one final status (kind 2); run_last marks the last result
// produced by an item.
// csr port: apb-style writes of timeout_ticks, start_code and ack_code at
// byte addresses 0, 4 and 8; pready is always high.
// Sequencing: an item is taken in S_IDLE and decoded in S_EXEC; an item
// with no result frees the input from S_EXEC, one with a single result once
// that result is loaded. The burst after the first DLE walks the command
// store, reading each byte in S_RD and loading it in S_BYTE, with an extra
// DLE result before each DLE byte, then loads three trailer results.
// Results leave through one output register; when the receiver stalls the
// sequencer holds until that register drains, and a new item is accepted
// while the last result of the previous item is still waiting.
// Reset (synchronous) returns to command collection with an empty command
// and restores the register defaults; the command store is not cleared.
module dle_framed_serial_command_exchange #(
   parameter int unsigned CMD_DEPTH = dfsc_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   dfsc_req_if.sink                         req,
   dfsc_rsp_if.source                       rsp,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [dfsc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   dfsc_pkg::dp_cmd_type  cmd;
   dfsc_pkg::dp_stat_type stat;
   logic [15:0]           timeout_ticks;
   logic [7:0]            start_code;
   logic [7:0]            ack_code;

   // configuration registers
   dfsc_regs u_regs (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .timeout_ticks (timeout_ticks),
      .start_code    (start_code),
      .ack_code      (ack_code)
   );

   // controller
   dfsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   dfsc_datapath #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req.func),
      .req_data_byte  (req.data_byte),
      .req_cmd_last   (req.cmd_last),
      .timeout_ticks  (timeout_ticks),
      .start_code     (start_code),
      .ack_code       (ack_code),
      .rsp_ready      (rsp.ready),
      .rsp_valid      (rsp.valid),
      .rsp_kind       (rsp.kind),
      .rsp_byte_value (rsp.byte_value),
      .rsp_status     (rsp.status),
      .rsp_run_last   (rsp.run_last)
   );

endmodule

// ===== hw/rtl/dfsc_regs.sv =====
// apb-style configuration registers: timeout, start code and acknowledge code
module dfsc_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dfsc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready,
   output logic [15:0]                       timeout_ticks,
   output logic [7:0]                        start_code,
   output logic [7:0]                        ack_code
);

   logic [15:0] timeout_ff;
   logic [7:0]  start_ff;
   logic [7:0]  ack_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= dfsc_pkg::TIMEOUT_RESET;
         start_ff   <= dfsc_pkg::START_RESET;
         ack_ff     <= dfsc_pkg::ACK_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            dfsc_pkg::REG_TIMEOUT: timeout_ff <= pwdata[15:0];
            dfsc_pkg::REG_START:   start_ff   <= pwdata[7:0];
            dfsc_pkg::REG_ACK:     ack_ff     <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read-back mux
   always_comb begin
      case (reg_idx)
         dfsc_pkg::REG_TIMEOUT: prdata = {16'h0000, timeout_ff};
         dfsc_pkg::REG_START:   prdata = {24'h000000, start_ff};
         dfsc_pkg::REG_ACK:     prdata = {24'h000000, ack_ff};
         default:               prdata = 32'h0000_0000;
      endcase
   end

   assign timeout_ticks = timeout_ff;
   assign start_code    = start_ff;
   assign ack_code      = ack_ff;

endmodule

// ===== hw/rtl/dfsc_datapath.sv =====
// datapath: item capture, command store, check byte, body/tail/timer counters, result register
module dfsc_datapath #(
   parameter int unsigned CMD_DEPTH = dfsc_pkg::CMD_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dfsc_pkg::dp_cmd_type    cmd,
   output dfsc_pkg::dp_stat_type   stat,
   input  logic [1:0]              req_func,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_cmd_last,
   input  logic [15:0]             timeout_ticks,
   input  logic [7:0]              start_code,
   input  logic [7:0]              ack_code,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_byte_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_run_last
);

   localparam int unsigned CNTW = $clog2(CMD_DEPTH + 1);
   localparam int unsigned IDXW = $clog2(CMD_DEPTH);

   // captured item
   logic [1:0]       func_ff;
   logic [7:0]       byte_ff;
   logic             last_ff;

   // command store and walk
   logic [7:0]       mem [CMD_DEPTH];
   logic [7:0]       rd_ff;
   logic [CNTW-1:0]  count_ff;
   logic [CNTW-1:0]  walk_ff;
   logic             full;

   // exchange counters
   logic [7:0]       acc_ff;
   logic [7:0]       len_ff;
   logic [7:0]       index_ff;
   logic             skip_ff;
   logic [1:0]       tail_ff;
   logic [15:0]      wait_ff;

   // result register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_kind_ff;
   logic [7:0]       rsp_byte_ff;
   logic [1:0]       rsp_status_ff;
   logic             rsp_last_ff;
   logic             can_load;
   logic [1:0]       kind_in;
   logic [7:0]       byte_in;
   logic [1:0]       status_in;

   assign full     = (count_ff >= CNTW'(CMD_DEPTH));
   assign can_load = !rsp_valid_ff || rsp_ready;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         func_ff <= req_func;
         byte_ff <= req_data_byte;
         last_ff <= req_cmd_last;
      end
   end

   // command store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.cmd_write && !full) begin
         mem[count_ff[IDXW-1:0]] <= byte_ff;
      end
      rd_ff <= mem[walk_ff[IDXW-1:0]];
   end

   // counters and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         acc_ff   <= '0;
         walk_ff  <= '0;
         len_ff   <= '0;
         index_ff <= '0;
         skip_ff  <= 1'b0;
         tail_ff  <= '0;
         wait_ff  <= '0;
      end else begin
         if (cmd.finish_clr) begin
            count_ff <= '0;
            acc_ff   <= '0;
         end else if (cmd.cmd_write && !full) begin
            count_ff <= count_ff + CNTW'(1);
            acc_ff   <= acc_ff ^ byte_ff;
         end

         if (cmd.walk_clr) begin
            walk_ff <= '0;
         end else if (cmd.walk_inc) begin
            walk_ff <= walk_ff + CNTW'(1);
         end

         if (cmd.finish_clr || cmd.wait_clr) begin
            wait_ff <= '0;
         end else if (cmd.wait_inc) begin
            wait_ff <= wait_ff + 16'd1;
         end

         if (cmd.len_load) begin
            len_ff   <= byte_ff;
            index_ff <= 8'd1;
         end else if (cmd.body_step) begin
            index_ff <= index_ff + 8'd1;
         end

         if (cmd.finish_clr || cmd.len_load || cmd.skip_clr) begin
            skip_ff <= 1'b0;
         end else if (cmd.body_step) begin
            skip_ff <= (byte_ff == dfsc_pkg::DLE_BYTE);
         end

         if (cmd.finish_clr || cmd.len_load || cmd.tail_clr) begin
            tail_ff <= '0;
         end else if (cmd.tail_inc) begin
            tail_ff <= tail_ff + 2'd1;
         end
      end
   end

   // result payload selection
   always_comb begin
      kind_in   = dfsc_pkg::KIND_TX;
      status_in = dfsc_pkg::ST_OK;
      case (cmd.sel)
         dfsc_pkg::SEL_START:  byte_in = start_code;
         dfsc_pkg::SEL_ACK:    byte_in = ack_code;
         dfsc_pkg::SEL_DLE:    byte_in = dfsc_pkg::DLE_BYTE;
         dfsc_pkg::SEL_ETX:    byte_in = dfsc_pkg::ETX_BYTE;
         dfsc_pkg::SEL_CHK:    byte_in = acc_ff ^ dfsc_pkg::DLE_BYTE ^ dfsc_pkg::ETX_BYTE;
         dfsc_pkg::SEL_CMD:    byte_in = rd_ff;
         dfsc_pkg::SEL_BODY: begin
            kind_in = dfsc_pkg::KIND_HOST;
            byte_in = byte_ff;
         end
         dfsc_pkg::SEL_STATUS: begin
            kind_in   = dfsc_pkg::KIND_STATUS;
            byte_in   = 8'h00;
            status_in = cmd.status;
         end
         default:              byte_in = 8'h00;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         rsp_kind_ff   <= kind_in;
         rsp_byte_ff   <= byte_in;
         rsp_status_ff <= status_in;
         rsp_last_ff   <= cmd.run_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_run_last   = rsp_last_ff;

   // status to the controller
   assign stat.func           = func_ff;
   assign stat.last           = last_ff;
   assign stat.byte_dle       = (byte_ff == dfsc_pkg::DLE_BYTE);
   assign stat.byte_stx       = (byte_ff == dfsc_pkg::STX_BYTE);
   assign stat.len_le1        = (byte_ff <= 8'd1);
   assign stat.timed_out      = (wait_ff >= timeout_ticks);
   assign stat.can_load       = can_load;
   assign stat.skip           = skip_ff;
   assign stat.body_done      = (index_ff >= len_ff);
   assign stat.body_done_next = (({1'b0, index_ff} + 9'd1) >= {1'b0, len_ff});
   assign stat.tail_end       = (({1'b0, tail_ff} + 3'd1) >= dfsc_pkg::TAIL_LEN);
   assign stat.rd_dle         = (rd_ff == dfsc_pkg::DLE_BYTE);
   assign stat.walk_end       = (({1'b0, walk_ff} + (CNTW + 1)'(1)) >= {1'b0, count_ff});
   assign stat.cnt_zero       = (count_ff == '0);

`ifndef SYNTHESIS
   // the controller only loads the result register when it is free or being drained
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> can_load)
      else $error("result register overwritten while holding an unsent item");

   // command count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(CMD_DEPTH))
      else $error("command count beyond store depth");

   // a status result always closes the run of results of its item
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == dfsc_pkg::KIND_STATUS)) |-> rsp_last_ff)
      else $error("status result not flagged as last");
`endif

endmodule

// ===== hw/rtl/dfsc_ctrl.sv =====
// controller: protocol phase and per-item sequencing of results
module dfsc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dfsc_pkg::dp_stat_type   stat,
   output dfsc_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_START,
      S_STATUS,
      S_ACK_END,
      S_ACK_TAIL,
      S_BODY,
      S_RD,
      S_BYTE,
      S_DATA,
      S_DLE_T,
      S_ETX,
      S_CHK
   } seq_type;

   typedef enum logic [2:0] {
      PH_COLLECT,
      PH_WAIT_DLE1,
      PH_WAIT_DLE2,
      PH_WAIT_STX,
      PH_WAIT_LEN,
      PH_BODY,
      PH_TAIL
   } phase_type;

   seq_type    seq_ff,   seq_in;
   phase_type  phase_ff, phase_in;
   logic [1:0] code_ff,  code_in;

   assign req_ready = (seq_ff == S_IDLE);

   // next state and datapath commands
   always_comb begin
      seq_in   = seq_ff;
      phase_in = phase_ff;
      code_in  = code_ff;
      cmd      = '0;
      case (seq_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               seq_in        = S_EXEC;
            end
         end

         // decide what the captured item does
         S_EXEC: begin
            seq_in = S_IDLE;
            if (phase_ff == PH_COLLECT) begin
               if (stat.func == dfsc_pkg::FUNC_CMD) begin
                  cmd.cmd_write = 1'b1;
                  if (stat.last) begin
                     cmd.wait_clr = 1'b1;
                     phase_in     = PH_WAIT_DLE1;
                     seq_in       = S_START;
                  end
               end
            end else if (stat.func == dfsc_pkg::FUNC_TICK) begin
               if (stat.timed_out) begin
                  code_in = dfsc_pkg::ST_TIMEOUT;
                  seq_in  = S_STATUS;
               end else begin
                  cmd.wait_inc = 1'b1;
               end
            end else if (stat.func == dfsc_pkg::FUNC_LINE) begin
               cmd.wait_clr = (phase_ff != PH_TAIL);
               case (phase_ff)
                  PH_WAIT_DLE1: begin
                     if (!stat.byte_dle) begin
                        code_in = dfsc_pkg::ST_PROTO;
                        seq_in  = S_STATUS;
                     end else begin
                        cmd.walk_clr = 1'b1;
                        phase_in     = PH_WAIT_DLE2;
                        seq_in       = stat.cnt_zero ? S_DLE_T : S_RD;
                     end
                  end
                  PH_WAIT_DLE2: begin
                     if (!stat.byte_dle) begin
                        code_in = dfsc_pkg::ST_PROTO;
                        seq_in  = S_STATUS;
                     end else begin
                        phase_in = PH_WAIT_STX;
                     end
                  end
                  PH_WAIT_STX: begin
                     if (!stat.byte_stx) begin
                        code_in = dfsc_pkg::ST_PROTO;
                        seq_in  = S_STATUS;
                     end else begin
                        phase_in = PH_WAIT_LEN;
                        seq_in   = S_ACK_END;
                     end
                  end
                  PH_WAIT_LEN: begin
                     cmd.len_load = 1'b1;
                     phase_in     = stat.len_le1 ? PH_TAIL : PH_BODY;
                     seq_in       = S_BODY;
                  end
                  PH_BODY: begin
                     if (stat.skip) begin
                        cmd.skip_clr = 1'b1;
                        if (stat.body_done) begin
                           cmd.tail_clr = 1'b1;
                           phase_in     = PH_TAIL;
                        end
                     end else begin
                        cmd.body_step = 1'b1;
                        if (!stat.byte_dle && stat.body_done_next) begin
                           cmd.tail_clr = 1'b1;
                           phase_in     = PH_TAIL;
                        end
                        seq_in = S_BODY;
                     end
                  end
                  PH_TAIL: begin
                     cmd.tail_inc = 1'b1;
                     if (stat.tail_end) begin
                        code_in = dfsc_pkg::ST_OK;
                        seq_in  = S_ACK_TAIL;
                     end
                  end
                  default: phase_in = PH_COLLECT;
               endcase
            end
         end

         // single result states
         S_START: begin
            if (stat.can_load) begin
               cmd.load     = 1'b1;
               cmd.sel      = dfsc_pkg::SEL_START;
               cmd.run_last = 1'b1;
               seq_in       = S_IDLE;
            end
         end
         S_STATUS: begin
            if (stat.can_load) begin
               cmd.load       = 1'b1;
               cmd.sel        = dfsc_pkg::SEL_STATUS;
               cmd.status     = code_ff;
               cmd.run_last   = 1'b1;
               cmd.finish_clr = 1'b1;
               phase_in       = PH_COLLECT;
               seq_in         = S_IDLE;
            end
         end
         S_ACK_END: begin
            if (stat.can_load) begin
               cmd.load     = 1'b1;
               cmd.sel      = dfsc_pkg::SEL_ACK;
               cmd.run_last = 1'b1;
               seq_in       = S_IDLE;
            end
         end
         S_ACK_TAIL: begin
            if (stat.can_load) begin
               cmd.load = 1'b1;
               cmd.sel  = dfsc_pkg::SEL_ACK;
               seq_in   = S_STATUS;
            end
         end
         S_BODY: begin
            if (stat.can_load) begin
               cmd.load     = 1'b1;
               cmd.sel      = dfsc_pkg::SEL_BODY;
               cmd.run_last = 1'b1;
               seq_in       = S_IDLE;
            end
         end

         // command walk: one store read per byte, DLE doubled
         S_RD: seq_in = S_BYTE;
         S_BYTE, S_DATA: begin
            if (stat.can_load) begin
               cmd.load = 1'b1;
               if (seq_ff == S_BYTE && stat.rd_dle) begin
                  cmd.sel = dfsc_pkg::SEL_DLE;
                  seq_in  = S_DATA;
               end else begin
                  cmd.sel      = dfsc_pkg::SEL_CMD;
                  cmd.walk_inc = 1'b1;
                  seq_in       = stat.walk_end ? S_DLE_T : S_RD;
               end
            end
         end
         S_DLE_T: begin
            if (stat.can_load) begin
               cmd.load = 1'b1;
               cmd.sel  = dfsc_pkg::SEL_DLE;
               seq_in   = S_ETX;
            end
         end
         S_ETX: begin
            if (stat.can_load) begin
               cmd.load = 1'b1;
               cmd.sel  = dfsc_pkg::SEL_ETX;
               seq_in   = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.can_load) begin
               cmd.load     = 1'b1;
               cmd.sel      = dfsc_pkg::SEL_CHK;
               cmd.run_last = 1'b1;
               seq_in       = S_IDLE;
            end
         end
         default: seq_in = S_IDLE;
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= S_IDLE;
         phase_ff <= PH_COLLECT;
         code_ff  <= dfsc_pkg::ST_OK;
      end else begin
         seq_ff   <= seq_in;
         phase_ff <= phase_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ===== tb/dle_framed_serial_command_exchange_tb.sv =====
// self-checking testbench for the framed serial command exchange engine
`timescale 1ns / 1ps

module dle_framed_serial_command_exchange_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_PAD  = 12;
   localparam int PHASE_ITEMS = 42;
   localparam int PHASES      = 9;

   // function code that the block ignores everywhere
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   // one request item and one result item
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data_byte;
      logic       cmd_last;
   } req_item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] byte_value;
      logic [1:0] status;
      logic       run_last;
   } rsp_item_type;

   // where the exchange stands
   typedef enum logic [2:0] {
      LK_COLLECT,
      LK_WAIT_DLE1,
      LK_WAIT_DLE2,
      LK_WAIT_STX,
      LK_WAIT_LEN,
      LK_BODY,
      LK_TAIL
   } link_phase_type;

   // predicts the exchange and checks results against it
   class exchange_scoreboard;
      logic [15:0]    timeout_ticks;
      logic [7:0]     start_code;
      logic [7:0]     ack_code;
      link_phase_type phase;
      logic [7:0]     cmd_bytes [dfsc_pkg::CMD_DEPTH_DEFAULT];
      int unsigned    cmd_count;
      logic [7:0]     check_xor;
      logic [7:0]     body_len;
      logic [7:0]     body_idx;
      logic           skip_byte;
      int unsigned    tail_seen;
      logic [15:0]    idle_ticks;
      rsp_item_type   step_out[$];
      rsp_item_type   awaited_outputs[$];
      int             fail_count;

      function new();
         timeout_ticks = dfsc_pkg::TIMEOUT_RESET;
         start_code    = dfsc_pkg::START_RESET;
         ack_code      = dfsc_pkg::ACK_RESET;
         phase         = LK_COLLECT;
         cmd_count     = 0;
         check_xor     = 8'h00;
         body_len      = 8'h00;
         body_idx      = 8'h00;
         skip_byte     = 1'b0;
         tail_seen     = 0;
         idle_ticks    = 16'h0000;
         fail_count    = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [31:0] value);
         case (index)
            dfsc_pkg::REG_TIMEOUT: timeout_ticks = value[15:0];
            dfsc_pkg::REG_START:   start_code    = value[7:0];
            dfsc_pkg::REG_ACK:     ack_code      = value[7:0];
            default: ;
         endcase
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] value, logic [1:0] status);
         rsp_item_type r;
         r.kind       = kind;
         r.byte_value = value;
         r.status     = status;
         r.run_last   = 1'b0;
         step_out.push_back(r);
      endfunction

      // status result, then back to collecting an empty command
      function void close_exchange(logic [1:0] status);
         emit(dfsc_pkg::KIND_STATUS, 8'h00, status);
         phase      = LK_COLLECT;
         cmd_count  = 0;
         check_xor  = 8'h00;
         skip_byte  = 1'b0;
         tail_seen  = 0;
         idle_ticks = 16'h0000;
      endfunction

      // work out the results of one accepted item
      function void advance_exchange(req_item_type it);
         logic [7:0] b;
         b = it.data_byte;
         step_out = {};
         if (phase == LK_COLLECT) begin
            if (it.func == dfsc_pkg::FUNC_CMD) begin
               // bytes past the store depth are dropped
               if (cmd_count < dfsc_pkg::CMD_DEPTH_DEFAULT) begin
                  cmd_bytes[cmd_count] = b;
                  cmd_count++;
                  check_xor ^= b;
               end
               if (it.cmd_last) begin
                  emit(dfsc_pkg::KIND_TX, start_code, dfsc_pkg::ST_OK);
                  phase      = LK_WAIT_DLE1;
                  idle_ticks = 16'h0000;
               end
            end
         end else if (it.func == dfsc_pkg::FUNC_TICK) begin
            if (idle_ticks >= timeout_ticks) close_exchange(dfsc_pkg::ST_TIMEOUT);
            else idle_ticks++;
         end else if (it.func == dfsc_pkg::FUNC_LINE) begin
            // the tail is timed as one wait
            if (phase != LK_TAIL) idle_ticks = 16'h0000;
            case (phase)
               LK_WAIT_DLE1: begin
                  if (b != dfsc_pkg::DLE_BYTE) begin
                     close_exchange(dfsc_pkg::ST_PROTO);
                  end else begin
                     for (int i = 0; i < cmd_count; i++) begin
                        if (cmd_bytes[i] == dfsc_pkg::DLE_BYTE)
                           emit(dfsc_pkg::KIND_TX, dfsc_pkg::DLE_BYTE, dfsc_pkg::ST_OK);
                        emit(dfsc_pkg::KIND_TX, cmd_bytes[i], dfsc_pkg::ST_OK);
                     end
                     check_xor ^= (dfsc_pkg::DLE_BYTE ^ dfsc_pkg::ETX_BYTE);
                     emit(dfsc_pkg::KIND_TX, dfsc_pkg::DLE_BYTE, dfsc_pkg::ST_OK);
                     emit(dfsc_pkg::KIND_TX, dfsc_pkg::ETX_BYTE, dfsc_pkg::ST_OK);
                     emit(dfsc_pkg::KIND_TX, check_xor, dfsc_pkg::ST_OK);
                     phase = LK_WAIT_DLE2;
                  end
               end
               LK_WAIT_DLE2: begin
                  if (b != dfsc_pkg::DLE_BYTE) close_exchange(dfsc_pkg::ST_PROTO);
                  else phase = LK_WAIT_STX;
               end
               LK_WAIT_STX: begin
                  if (b != dfsc_pkg::STX_BYTE) begin
                     close_exchange(dfsc_pkg::ST_PROTO);
                  end else begin
                     emit(dfsc_pkg::KIND_TX, ack_code, dfsc_pkg::ST_OK);
                     phase = LK_WAIT_LEN;
                  end
               end
               LK_WAIT_LEN: begin
                  body_len  = b;
                  body_idx  = 8'd1;
                  skip_byte = 1'b0;
                  tail_seen = 0;
                  emit(dfsc_pkg::KIND_HOST, b, dfsc_pkg::ST_OK);
                  phase = (b <= 8'd1) ? LK_TAIL : LK_BODY;
               end
               LK_BODY: begin
                  // the byte after a DLE is dropped
                  if (skip_byte) begin
                     skip_byte = 1'b0;
                  end else begin
                     emit(dfsc_pkg::KIND_HOST, b, dfsc_pkg::ST_OK);
                     if (b == dfsc_pkg::DLE_BYTE) skip_byte = 1'b1;
                     body_idx++;
                  end
                  if (!skip_byte && body_idx >= body_len) begin
                     phase     = LK_TAIL;
                     tail_seen = 0;
                  end
               end
               LK_TAIL: begin
                  tail_seen++;
                  if (tail_seen >= dfsc_pkg::TAIL_LEN) begin
                     emit(dfsc_pkg::KIND_TX, ack_code, dfsc_pkg::ST_OK);
                     close_exchange(dfsc_pkg::ST_OK);
                  end
               end
               default: phase = LK_COLLECT;
            endcase
         end
         if (step_out.size() > 0) step_out[step_out.size() - 1].run_last = 1'b1;
         foreach (step_out[i]) awaited_outputs.push_back(step_out[i]);
      endfunction

      task report_mismatch(string msg);
         fail_count++;
         $display("mismatch: %s", msg);
      endtask

      task check_result(rsp_item_type got);
         rsp_item_type want;
         if (awaited_outputs.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind %0d byte %02h status %0d last %0d",
                                      got.kind, got.byte_value, got.status, got.run_last));
         end else begin
            want = awaited_outputs.pop_front();
            if (got.kind !== want.kind || got.byte_value !== want.byte_value ||
                got.status !== want.status || got.run_last !== want.run_last)
               report_mismatch($sformatf(
                  "got kind %0d byte %02h status %0d last %0d, want %0d %02h %0d %0d",
                  got.kind, got.byte_value, got.status, got.run_last,
                  want.kind, want.byte_value, want.status, want.run_last));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [dfsc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dfsc_req_if req_ch ();
   dfsc_rsp_if rsp_ch ();

   dle_framed_serial_command_exchange dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   exchange_scoreboard sb;
   req_item_type stim[$];
   int idle_mode = 0;
   int cycle_count = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dle_framed_serial_command_exchange test failed");
         $finish;
      end
   end

   // receiver stalls in modes 2 and 3
   always @(posedge clock) begin
      if (idle_mode == 2) rsp_ch.ready <= ($urandom_range(99) >= 46);
      else if (idle_mode == 3) rsp_ch.ready <= ($urandom_range(99) >= 28);
      else rsp_ch.ready <= 1'b1;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_item_type got;
      req_item_type taken;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind       = rsp_ch.kind;
            got.byte_value = rsp_ch.byte_value;
            got.status     = rsp_ch.status;
            got.run_last   = rsp_ch.run_last;
            sb.check_result(got);
         end
         if (req_ch.valid && req_ch.ready) begin
            taken.func      = req_ch.func;
            taken.data_byte = req_ch.data_byte;
            taken.cmd_last  = req_ch.cmd_last;
            sb.advance_exchange(taken);
         end
      end
   end

   function automatic void queue_item(logic [1:0] f, logic [7:0] d, logic l);
      req_item_type it;
      it.func      = f;
      it.data_byte = d;
      it.cmd_last  = l;
      stim.push_back(it);
   endfunction

   // random byte with DLE one time in five
   function automatic logic [7:0] pick_byte();
      if ($urandom_range(4) == 0) return dfsc_pkg::DLE_BYTE;
      return 8'($urandom_range(255));
   endfunction

   // items the block should ignore in the current phase
   function automatic void queue_noise(logic collecting);
      int r;
      r = $urandom_range(2);
      if (r == 0) queue_item(FUNC_SPARE, 8'($urandom_range(255)), 1'($urandom_range(1)));
      else if (collecting && r == 1)
         queue_item(dfsc_pkg::FUNC_TICK, 8'($urandom_range(255)), 1'b0);
      else if (collecting)
         queue_item(dfsc_pkg::FUNC_LINE, pick_byte(), 1'($urandom_range(1)));
      else queue_item(dfsc_pkg::FUNC_CMD, pick_byte(), 1'($urandom_range(1)));
   endfunction

   // ticks while waiting; returns 1 when they run into the timeout
   function automatic logic queue_wait();
      int n;
      if (sb.timeout_ticks <= 16 && $urandom_range(24) == 0) begin
         repeat (int'(sb.timeout_ticks) + 1)
            queue_item(dfsc_pkg::FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
         return 1'b1;
      end
      n = 0;
      if ($urandom_range(3) == 0)
         n = $urandom_range(0, (sb.timeout_ticks < 2) ? int'(sb.timeout_ticks) : 2);
      repeat (n)
         queue_item(dfsc_pkg::FUNC_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
      return 1'b0;
   endfunction

   // handshake byte, wrong one time in twenty; returns 1 when wrong
   function automatic logic queue_handshake(logic [7:0] good);
      if ($urandom_range(19) == 0) begin
         queue_item(dfsc_pkg::FUNC_LINE, good ^ 8'($urandom_range(1, 255)),
                    1'($urandom_range(1)));
         return 1'b1;
      end
      queue_item(dfsc_pkg::FUNC_LINE, good, 1'($urandom_range(1)));
      return 1'b0;
   endfunction

   // one full exchange with random content, broken now and then
   function automatic void queue_exchange();
      int n_cmd;
      int len;
      int idx;
      int r;
      logic [7:0] b;
      n_cmd = ($urandom_range(9) == 0) ? $urandom_range(17, 20) : $urandom_range(1, 16);
      for (int k = 0; k < n_cmd; k++) begin
         if ($urandom_range(11) == 0) queue_noise(1'b1);
         queue_item(dfsc_pkg::FUNC_CMD, pick_byte(), k == n_cmd - 1);
      end
      if (queue_wait()) return;
      if (queue_handshake(dfsc_pkg::DLE_BYTE)) return;
      if ($urandom_range(9) == 0) queue_noise(1'b0);
      if (queue_wait()) return;
      if (queue_handshake(dfsc_pkg::DLE_BYTE)) return;
      if (queue_wait()) return;
      if (queue_handshake(dfsc_pkg::STX_BYTE)) return;
      if (queue_wait()) return;
      r = $urandom_range(15);
      if (r == 0) len = $urandom_range(0, 1);
      else if (r == 1) len = 16;
      else if (r == 2) len = $urandom_range(17, 40);
      else len = $urandom_range(2, 8);
      queue_item(dfsc_pkg::FUNC_LINE, 8'(len), 1'($urandom_range(1)));
      idx = 1;
      while (idx < len) begin
         if (queue_wait()) return;
         b = pick_byte();
         queue_item(dfsc_pkg::FUNC_LINE, b, 1'($urandom_range(1)));
         if (b == dfsc_pkg::DLE_BYTE)
            queue_item(dfsc_pkg::FUNC_LINE, pick_byte(), 1'($urandom_range(1)));
         idx++;
      end
      repeat (3) queue_item(dfsc_pkg::FUNC_LINE, pick_byte(), 1'($urandom_range(1)));
      if ($urandom_range(7) == 0) queue_noise(1'b1);
   endfunction

   // short directed run, meant for a timeout of one tick
   function automatic void queue_directed();
      // ignored while collecting
      queue_item(dfsc_pkg::FUNC_TICK, 8'h00, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b0);
      queue_item(FUNC_SPARE, 8'hFF, 1'b1);
      // good exchange: a DLE doubled in the command, a DLE and dropped byte in the body
      queue_item(dfsc_pkg::FUNC_CMD, 8'h00, 1'b0);
      queue_item(dfsc_pkg::FUNC_CMD, dfsc_pkg::DLE_BYTE, 1'b0);
      queue_item(dfsc_pkg::FUNC_CMD, 8'hFF, 1'b1);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b1);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::STX_BYTE, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'h03, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'hAA, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'h55, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'h00, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'hFF, 1'b1);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b0);
      // wrong first handshake byte
      queue_item(dfsc_pkg::FUNC_CMD, 8'h5A, 1'b1);
      queue_item(dfsc_pkg::FUNC_TICK, 8'hFF, 1'b0);
      queue_item(dfsc_pkg::FUNC_LINE, 8'h11, 1'b0);
      // timeout while waiting for the second DLE
      queue_item(dfsc_pkg::FUNC_CMD, 8'h01, 1'b1);
      queue_item(dfsc_pkg::FUNC_LINE, dfsc_pkg::DLE_BYTE, 1'b0);
      queue_item(dfsc_pkg::FUNC_TICK, 8'h00, 1'b0);
      queue_item(dfsc_pkg::FUNC_TICK, 8'h00, 1'b0);
   endfunction

   // apb write: setup phase, access phase, then psel dropped
   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_register(index, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input int ph);
      logic [15:0] tmo;
      logic [7:0]  st;
      logic [7:0]  ak;
      if (ph == 1) begin
         tmo = 16'd1;
         st  = 8'h00;
         ak  = 8'hFF;
      end else if (ph == 2) begin
         tmo = 16'hFFFF;
         st  = 8'hFF;
         ak  = 8'h00;
      end else begin
         tmo = ($urandom_range(5) == 0) ? 16'($urandom_range(100, 400))
                                        : 16'($urandom_range(1, 12));
         st  = 8'($urandom_range(255));
         ak  = ($urandom_range(2) == 0) ? dfsc_pkg::ACK_RESET : 8'($urandom_range(255));
      end
      write_register(dfsc_pkg::REG_TIMEOUT, {16'h0000, tmo});
      write_register(dfsc_pkg::REG_START, {24'h000000, st});
      write_register(dfsc_pkg::REG_ACK, {24'h000000, ak});
   endtask

   // push the queued items through the request channel
   task automatic send_items();
      req_item_type it;
      int gap;
      while (stim.size() > 0) begin
         it  = stim.pop_front();
         gap = 0;
         if (idle_mode == 1) while ($urandom_range(99) < 46) gap++;
         else if (idle_mode == 3) while ($urandom_range(99) < 28) gap++;
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.func      <= it.func;
         req_ch.data_byte <= it.data_byte;
         req_ch.cmd_last  <= it.cmd_last;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
      end
      req_ch.valid <= 1'b0;
   endtask

   // wait for outstanding results, then let the block go quiet
   task automatic settle();
      int waited;
      waited = 0;
      while (sb.awaited_outputs.size() > 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_PAD) @(posedge clock);
   endtask

   initial begin
      sb = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.func      <= dfsc_pkg::FUNC_CMD;
      req_ch.data_byte <= 8'h00;
      req_ch.cmd_last  <= 1'b0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= 32'h0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // phase 0 runs on the reset defaults
      for (int ph = 0; ph < PHASES; ph++) begin
         idle_mode = ph % 4;
         if (ph > 0) configure(ph);
         if (ph == 1) queue_directed();
         while (stim.size() < PHASE_ITEMS) queue_exchange();
         send_items();
         settle();
      end

      if (sb.awaited_outputs.size() > 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived",
                                      sb.awaited_outputs.size()));
      if (sb.fail_count == 0) begin
         $display("dle_framed_serial_command_exchange test passed");
      end else begin
         $display("dle_framed_serial_command_exchange test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dfsc_pkg.sv
hw/rtl/dfsc_channels.sv
hw/rtl/dfsc_regs.sv
hw/rtl/dfsc_datapath.sv
hw/rtl/dfsc_ctrl.sv
hw/rtl/dle_framed_serial_command_exchange.sv
tb/dle_framed_serial_command_exchange_tb.sv
